/* rtl/sdm_pkg.sv */
package sdm_pkg;

	localparam int DEFAULT_SAMPLE_DEPTH = 65536;
	localparam int NUM_CH = 4;
	localparam int MAX_ADDR_W = 24;
	localparam logic [15:0] MIN_PERIOD = 16'd100;
	localparam logic [23:0] TICK_RELOAD_RST = 24'd1000;

	typedef enum logic [1:0] {
		REQ_TICK = 2'd0,
		REQ_MEM_WR = 2'd1,
		REQ_REG_WR = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		SEL_START = 3'd0,
		SEL_LENGTH = 3'd1,
		SEL_PERIOD = 3'd2,
		SEL_VOLUME = 3'd3,
		SEL_CONTROL = 3'd4,
		SEL_PEND_START = 3'd5,
		SEL_PEND_LENGTH = 3'd6,
		SEL_PEND_ADD = 3'd7
	} reg_sel_t;

	typedef struct packed {
		logic [MAX_ADDR_W-1:0] addr;
		logic [7:0] vol;
		logic snd;
	} voice_t;

endpackage

/* rtl/four_channel_sample_dma_mixer.sv */
// Four-channel sample player and stereo mixer. A sample tick transaction yields one result
// after acceptance: the four channel samples are fetched one per cycle
// through the single read port of the sample memory, then summed. Memory and register
// write transactions give no result. The input stalls from an accepted tick until its
// result has moved into the output register.
module four_channel_sample_dma_mixer import sdm_pkg::*; #(
	parameter int SAMPLE_DEPTH = DEFAULT_SAMPLE_DEPTH
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// channel[1:0], reg_select[4:2], address[20:5], wdata[36:21], zero fill
	input logic [39:0] s_tdata,
	// req_type[1:0]
	input logic [1:0] s_tuser,
	output logic m_tvalid,
	input logic m_tready,
	// left_out[15:0], right_out[31:16], loop_flags[35:32], zero fill
	output logic [39:0] m_tdata,
	// tick_pulse[0]
	output logic m_tuser,
	input logic cfg_we,
	input logic [23:0] cfg_wdata
);

	localparam int ADDR_W = $clog2(SAMPLE_DEPTH);

	logic acc;
	logic tick_acc;
	logic mem_acc;
	logic reg_acc;
	logic busy_q;
	logic [23:0] reload_q;
	logic [23:0] tcount_q;
	logic pulse_q;
	logic [NUM_CH-1:0] flags_q;
	logic [NUM_CH-1:0] flags;
	voice_t voice [NUM_CH];
	logic done;
	logic take;
	logic [15:0] left;
	logic [15:0] right;
	logic m_tvalid_q;
	logic [39:0] m_tdata_q;
	logic m_tuser_q;
	logic [24:0] waddr;

	assign s_tready = !busy_q;
	assign acc = s_tvalid && s_tready;
	assign tick_acc = acc && s_tuser == REQ_TICK;
	assign mem_acc = acc && s_tuser == REQ_MEM_WR;
	assign reg_acc = acc && s_tuser == REQ_REG_WR;
	assign take = done && (!m_tvalid_q || m_tready);
	assign waddr = {9'd0, s_tdata[20:5]};

	sdm_chan u_chan (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(reg_acc),
		.wr_ch(s_tdata[1:0]),
		.wr_sel(reg_sel_t'(s_tdata[4:2])),
		.wr_data(s_tdata[36:21]),
		.tick_en(tick_acc),
		.voice(voice),
		.flags(flags)
	);

	sdm_mix #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) u_mix (
		.clk(clk),
		.arst_n(arst_n),
		.mem_we(mem_acc),
		.mem_addr(waddr[ADDR_W-1:0]),
		.mem_data(s_tdata[28:21]),
		.start(tick_acc),
		.voice_in(voice),
		.take(take),
		.done(done),
		.left(left),
		.right(right)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q <= TICK_RELOAD_RST;
			tcount_q <= '0;
			busy_q <= 1'b0;
			pulse_q <= 1'b0;
			flags_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
			m_tuser_q <= 1'b0;
		end else begin
			if (cfg_we)
				reload_q <= cfg_wdata;
			if (tick_acc) begin
				busy_q <= 1'b1;
				flags_q <= flags;
				if (tcount_q == 24'd0) begin
					tcount_q <= reload_q;
					pulse_q <= 1'b1;
				end else begin
					tcount_q <= tcount_q - 24'd1;
					pulse_q <= 1'b0;
				end
			end
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			if (take) begin
				busy_q <= 1'b0;
				m_tvalid_q <= 1'b1;
				m_tdata_q <= {4'd0, flags_q, right, left};
				m_tuser_q <= pulse_q;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	a_busy_after_tick: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> busy_q) else $error("tick not holding input");
	a_take_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> busy_q) else $error("result without tick");
	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> m_tvalid_q && !busy_q) else $error("result lost");

endmodule

/* rtl/sdm_chan.sv */
module sdm_chan import sdm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [1:0] wr_ch,
	input reg_sel_t wr_sel,
	input logic [15:0] wr_data,
	input logic tick_en,
	output voice_t voice [NUM_CH],
	output logic [NUM_CH-1:0] flags
);

	logic on_q [NUM_CH];
	logic looping_q [NUM_CH];
	logic muted_q [NUM_CH];
	logic [15:0] start_q [NUM_CH];
	logic [15:0] len_q [NUM_CH];
	logic [16:0] off_q [NUM_CH];
	logic [16:0] cd_q [NUM_CH];
	logic [15:0] period_q [NUM_CH];
	logic [7:0] vol_q [NUM_CH];
	logic ps_vld_q [NUM_CH];
	logic [15:0] ps_q [NUM_CH];
	logic pl_vld_q [NUM_CH];
	logic [15:0] pl_q [NUM_CH];
	logic [15:0] padd_q [NUM_CH];

	logic nxt_on [NUM_CH];
	logic [15:0] nxt_start [NUM_CH];
	logic [15:0] nxt_len [NUM_CH];
	logic [16:0] nxt_off [NUM_CH];
	logic [16:0] nxt_cd [NUM_CH];
	logic nxt_loop [NUM_CH];
	logic [16:0] off1 [NUM_CH];
	logic [24:0] sum [NUM_CH];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			nxt_on[c] = on_q[c];
			nxt_start[c] = start_q[c];
			nxt_len[c] = len_q[c];
			nxt_off[c] = off_q[c];
			nxt_cd[c] = cd_q[c];
			nxt_loop[c] = 1'b0;
			off1[c] = off_q[c] + 17'd1;
			if (on_q[c] && period_q[c] >= MIN_PERIOD) begin
				if (cd_q[c] == 17'd0) begin
					nxt_cd[c] = {1'b0, period_q[c]};
					nxt_off[c] = off1[c];
					if (off1[c] >= {len_q[c], 1'b0}) begin
						nxt_loop[c] = 1'b1;
						nxt_off[c] = 17'd0;
						if (ps_vld_q[c])
							nxt_start[c] = ps_q[c];
						if (pl_vld_q[c])
							nxt_len[c] = pl_q[c];
						if (padd_q[c] != 16'd0)
							nxt_start[c] = nxt_start[c] + padd_q[c];
						if (!looping_q[c])
							nxt_on[c] = 1'b0;
					end
				end else begin
					nxt_cd[c] = cd_q[c] - 17'd1;
				end
			end
			sum[c] = {9'd0, nxt_start[c]} + {8'd0, nxt_off[c]};
			voice[c].addr = sum[c][MAX_ADDR_W-1:0];
			voice[c].vol = vol_q[c];
			voice[c].snd = on_q[c] && !muted_q[c];
			flags[c] = nxt_loop[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				on_q[c] <= 1'b0;
				looping_q[c] <= 1'b1;
				muted_q[c] <= 1'b0;
				start_q[c] <= '0;
				len_q[c] <= '0;
				off_q[c] <= '0;
				cd_q[c] <= '0;
				period_q[c] <= '0;
				vol_q[c] <= '0;
				ps_vld_q[c] <= 1'b0;
				ps_q[c] <= '0;
				pl_vld_q[c] <= 1'b0;
				pl_q[c] <= '0;
				padd_q[c] <= '0;
			end
		end else if (tick_en) begin
			for (int c = 0; c < NUM_CH; c++) begin
				on_q[c] <= nxt_on[c];
				start_q[c] <= nxt_start[c];
				len_q[c] <= nxt_len[c];
				off_q[c] <= nxt_off[c];
				cd_q[c] <= nxt_cd[c];
				if (nxt_loop[c]) begin
					ps_vld_q[c] <= 1'b0;
					pl_vld_q[c] <= 1'b0;
					padd_q[c] <= '0;
				end
			end
		end else if (wr_en) begin
			unique case (wr_sel)
				SEL_START: start_q[wr_ch] <= wr_data;
				SEL_LENGTH: len_q[wr_ch] <= wr_data;
				SEL_PERIOD: period_q[wr_ch] <= wr_data;
				SEL_VOLUME: vol_q[wr_ch] <= wr_data[7:0];
				SEL_CONTROL: begin
					on_q[wr_ch] <= wr_data[0];
					looping_q[wr_ch] <= wr_data[1];
					muted_q[wr_ch] <= wr_data[2];
				end
				SEL_PEND_START: begin
					ps_q[wr_ch] <= wr_data;
					ps_vld_q[wr_ch] <= 1'b1;
				end
				SEL_PEND_LENGTH: begin
					pl_q[wr_ch] <= wr_data;
					pl_vld_q[wr_ch] <= 1'b1;
				end
				SEL_PEND_ADD: padd_q[wr_ch] <= wr_data;
				default: ;
			endcase
		end
	end

endmodule

/* rtl/sdm_mix.sv */
module sdm_mix import sdm_pkg::*; #(
	parameter int SAMPLE_DEPTH = DEFAULT_SAMPLE_DEPTH,
	localparam int ADDR_W = $clog2(SAMPLE_DEPTH)
) (
	input logic clk,
	input logic arst_n,
	input logic mem_we,
	input logic [ADDR_W-1:0] mem_addr,
	input logic [7:0] mem_data,
	input logic start,
	input voice_t voice_in [NUM_CH],
	input logic take,
	output logic done,
	output logic [15:0] left,
	output logic [15:0] right
);

	logic [7:0] mem [SAMPLE_DEPTH];
	voice_t voice_s1 [NUM_CH];
	logic [1:0] rd_idx_q;
	logic rd_on_q;
	logic rd_vld_s2;
	logic [1:0] idx_s2;
	logic [7:0] rdata_s2;
	logic done_q;
	logic [15:0] left_q;
	logic [15:0] right_q;
	logic [ADDR_W-1:0] rd_addr;
	logic signed [16:0] prod;
	logic [15:0] term;

	assign rd_addr = voice_s1[rd_idx_q].addr[ADDR_W-1:0];
	assign prod = $signed(rdata_s2) * $signed({1'b0, voice_s1[idx_s2].vol});
	assign term = voice_s1[idx_s2].snd ? prod[15:0] : 16'd0;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_data;
		rdata_s2 <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (start)
			voice_s1 <= voice_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			rd_on_q <= 1'b0;
			rd_vld_s2 <= 1'b0;
			idx_s2 <= '0;
			done_q <= 1'b0;
			left_q <= '0;
			right_q <= '0;
		end else begin
			rd_vld_s2 <= rd_on_q;
			idx_s2 <= rd_idx_q;
			if (start) begin
				rd_on_q <= 1'b1;
				rd_idx_q <= '0;
				left_q <= '0;
				right_q <= '0;
			end else if (rd_on_q) begin
				rd_idx_q <= rd_idx_q + 2'd1;
				if (rd_idx_q == 2'd3)
					rd_on_q <= 1'b0;
			end
			if (rd_vld_s2) begin
				if (idx_s2 == 2'd0 || idx_s2 == 2'd3)
					left_q <= left_q + term;
				else
					right_q <= right_q + term;
				if (idx_s2 == 2'd3)
					done_q <= 1'b1;
			end
			if (take)
				done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign left = left_q;
	assign right = right_q;

	a_no_write_during_read: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !rd_on_q && !rd_vld_s2) else $error("sample write during read sweep");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !rd_on_q && !rd_vld_s2 && !done_q) else $error("tick while mixing");
	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(rd_vld_s2) && $past(idx_s2) == 2'd3)
		else $error("result without last read");

endmodule
